>>> rtl/core/qbz_pkg.sv
// Shared types and constants for the quintic Bezier coefficient and sample unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qbz_pkg;

    localparam int NPTS      = 5;                 // path points per item
    localparam int DEGREE    = 5;                 // curve degree
    localparam int NCOEF     = DEGREE + 1;        // control points / coefficients
    localparam int PC_W      = 3;                 // point_count width
    localparam int PT_W      = 16;                // Q8.8 coordinate
    localparam int PT_IDX_W  = $clog2(NPTS);
    localparam int COEF_W    = 24;                // power-basis coefficient
    localparam int ACC_W     = 44;                // Horner accumulator
    localparam int IDX_W     = 4;                 // item_index width
    localparam int CNT_W     = 5;                 // per-item result counter
    localparam int VAL_W     = 24;                // x_value / y_value width
    localparam int IN_DATA_W  = 168;              // 163 used bits, byte padded
    localparam int OUT_DATA_W = 56;               // 52 used bits, byte padded

    // 10^i for the Horner terms
    localparam logic signed [ACC_W-1:0] POW10 [NCOEF] =
        '{44'sd1, 44'sd10, 44'sd100, 44'sd1000, 44'sd10000, 44'sd100000};

    typedef enum logic {
        KIND_COEF   = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef logic [NPTS-1:0][PT_W-1:0]    pt_vec_t;
    typedef logic [NCOEF-1:0][PT_W-1:0]   cp_vec_t;
    typedef logic [NCOEF-1:0][COEF_W-1:0] coef_vec_t;
    typedef logic [NCOEF-1:0][ACC_W-1:0]  scl_vec_t;

    // one coefficient set, raw and scaled by 10^i
    typedef struct packed {
        coef_vec_t cx;
        coef_vec_t cy;
        scl_vec_t  sx;
        scl_vec_t  sy;
    } coef_set_t;

    // one result slot in the evaluation pipeline
    typedef struct packed {
        kind_t                   kind;
        logic [IDX_W-1:0]        idx;
        logic                    last;
        logic [IDX_W-1:0]        k;
        logic signed [ACC_W-1:0] acc_x;
        logic signed [ACC_W-1:0] acc_y;
        scl_vec_t                sx;
        scl_vec_t                sy;
    } hslot_t;

endpackage

`default_nettype wire

>>> rtl/core/quintic_bezier_coeffs_and_samples_unit.sv
// Quintic Bezier coefficients and samples: 6 + SAMPLE_COUNT results per item.
// The sequencer takes a new coefficient set only once every result of the last
// one is issued; it issues one result per cycle into the evaluation pipeline
// while the output item is not held.
// Reset (rst_n, async, active low) clears valid bits and the result counter.
`timescale 1ns / 1ps
`default_nettype none

module quintic_bezier_coeffs_and_samples_unit #(
    parameter int SAMPLE_COUNT = 11
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] point_count, then 16 bits each from bit 3 up: first_x, first_y,
    // second_x, second_y, third_x, third_y, fourth_x, fourth_y, fifth_x,
    // fifth_y; [167:163] zero
    input  wire logic [qbz_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] item_index, [27:4] x_value, [51:28] y_value, [55:52] zero
    output logic [qbz_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] kind: 0 coefficient pair, 1 curve sample
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    import qbz_pkg::*;

    logic [PC_W-1:0] point_count;
    pt_vec_t         pt_x, pt_y;
    logic            set_valid, set_take;
    coef_set_t       set_data;
    logic            hv;
    hslot_t          hslot;
    logic            en;
    kind_t           res_kind;
    logic [IDX_W-1:0] res_idx;
    logic [VAL_W-1:0] res_x, res_y;

    // unpack the input item
    always_comb
    begin
        point_count = s_axis_tdata[PC_W-1:0];
        for (int i = 0; i < NPTS; i++)
        begin
            pt_x[i] = s_axis_tdata[PC_W + 2 * PT_W * i +: PT_W];
            pt_y[i] = s_axis_tdata[PC_W + 2 * PT_W * i + PT_W +: PT_W];
        end
    end

    // back end advances in lock step unless the output item is held
    assign en = !m_axis_tvalid || m_axis_tready;

    qbz_coeff u_coeff (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .point_count (point_count),
        .pt_x        (pt_x),
        .pt_y        (pt_y),
        .set_valid   (set_valid),
        .set_data    (set_data),
        .set_take    (set_take)
    );

    qbz_horner #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .set_valid (set_valid),
        .set_data  (set_data),
        .set_take  (set_take),
        .out_valid (hv),
        .out_slot  (hslot)
    );

    qbz_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hv),
        .in_slot   (hslot),
        .out_valid (m_axis_tvalid),
        .out_kind  (res_kind),
        .out_idx   (res_idx),
        .out_last  (m_axis_tlast),
        .out_x     (res_x),
        .out_y     (res_y)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - IDX_W - 2 * VAL_W){1'b0}}, res_y, res_x, res_idx};
    assign m_axis_tuser = res_kind;

endmodule

`default_nettype wire

>>> rtl/core/qbz_coeff.sv
// Front end: control point placement, power-basis coefficients, 10^i scaling.
// Three register stages with valid/ready; depends on qbz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbz_coeff (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [qbz_pkg::PC_W-1:0] point_count,
    input  wire qbz_pkg::pt_vec_t     pt_x,
    input  wire qbz_pkg::pt_vec_t     pt_y,
    output logic                      set_valid,
    output qbz_pkg::coef_set_t        set_data,
    input  wire logic                 set_take
);
    import qbz_pkg::*;

    logic      v1_reg, v2_reg, v3_reg;
    cp_vec_t   cpx_reg, cpy_reg, cpx_next, cpy_next;
    coef_vec_t cx2_reg, cy2_reg;
    coef_set_t set_reg, set_next;
    logic      rdy1, rdy2, rdy3;

    function automatic coef_vec_t make_coeffs(input cp_vec_t p);
        logic signed [COEF_W-1:0] q [NCOEF];
        coef_vec_t c;
        for (int i = 0; i < NCOEF; i++)
        begin
            q[i] = COEF_W'($signed(p[i]));
        end
        c[0] = COEF_W'(-q[0] + 5 * q[1] - 10 * q[2] + 10 * q[3] - 5 * q[4] + q[5]);
        c[1] = COEF_W'(5 * q[0] - 20 * q[1] + 30 * q[2] - 20 * q[3] + 5 * q[4]);
        c[2] = COEF_W'(-10 * q[0] + 30 * q[1] - 30 * q[2] + 10 * q[3]);
        c[3] = COEF_W'(10 * q[0] - 20 * q[1] + 10 * q[2]);
        c[4] = COEF_W'(-5 * q[0] + 5 * q[1]);
        c[5] = q[0];
        return c;
    endfunction

    assign rdy3     = !v3_reg || set_take;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // n points fill the last n slots, slot 0 stays at the origin
    always_comb
    begin
        logic [PC_W-1:0] cnt;
        int              sel;
        cnt      = (point_count > PC_W'(DEGREE)) ? PC_W'(DEGREE) : point_count;
        cpx_next = '0;
        cpy_next = '0;
        for (int j = 1; j < NCOEF; j++)
        begin
            sel = j + int'(cnt) - NCOEF;
            if (sel >= 0)
            begin
                cpx_next[j] = pt_x[sel[PT_IDX_W-1:0]];
                cpy_next[j] = pt_y[sel[PT_IDX_W-1:0]];
            end
        end
    end

    always_comb
    begin
        set_next.cx = cx2_reg;
        set_next.cy = cy2_reg;
        for (int i = 0; i < NCOEF; i++)
        begin
            set_next.sx[i] = ACC_W'($signed(cx2_reg[i])) * POW10[i];
            set_next.sy[i] = ACC_W'($signed(cy2_reg[i])) * POW10[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            cpx_reg <= cpx_next;
            cpy_reg <= cpy_next;
        end
        if (rdy2)
        begin
            cx2_reg <= make_coeffs(cpx_reg);
            cy2_reg <= make_coeffs(cpy_reg);
        end
        if (rdy3)
            set_reg <= set_next;
    end

    assign set_valid = v3_reg;
    assign set_data  = set_reg;

endmodule

`default_nettype wire

>>> rtl/core/qbz_horner.sv
// Result sequencer and Horner pipeline: one result slot issued per cycle
// while en is high, five multiply-add stages. Depends on qbz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbz_horner #(
    parameter int SAMPLE_COUNT = 11
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               set_valid,
    input  wire qbz_pkg::coef_set_t set_data,
    output logic                    set_take,
    output logic                    out_valid,
    output qbz_pkg::hslot_t         out_slot
);
    import qbz_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NCOEF + SAMPLE_COUNT - 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hv_reg  [NCOEF];
    hslot_t           hs_reg  [NCOEF];
    hslot_t           hs_next [NCOEF];
    logic             at_last;

    assign at_last  = (cnt_reg == LAST_CNT);
    assign set_take = en && set_valid && at_last;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (en && set_valid)
            cnt_next = at_last ? '0 : cnt_reg + CNT_W'(1);
    end

    // issue: coefficients first, then samples seeded with c0
    always_comb
    begin
        hs_next[0].sx   = set_data.sx;
        hs_next[0].sy   = set_data.sy;
        hs_next[0].last = at_last;
        if (cnt_reg < CNT_W'(NCOEF))
        begin
            hs_next[0].kind  = KIND_COEF;
            hs_next[0].idx   = cnt_reg[IDX_W-1:0];
            hs_next[0].k     = '0;
            hs_next[0].acc_x = ACC_W'($signed(set_data.cx[cnt_reg[PT_IDX_W-1:0]]));
            hs_next[0].acc_y = ACC_W'($signed(set_data.cy[cnt_reg[PT_IDX_W-1:0]]));
        end
        else
        begin
            hs_next[0].kind  = KIND_SAMPLE;
            hs_next[0].idx   = IDX_W'(cnt_reg - CNT_W'(NCOEF));
            hs_next[0].k     = IDX_W'(cnt_reg - CNT_W'(NCOEF));
            hs_next[0].acc_x = $signed(set_data.sx[0]);
            hs_next[0].acc_y = $signed(set_data.sy[0]);
        end
    end

    // stage g: acc = acc * k + c_g * 10^g
    for (genvar g = 1; g < NCOEF; g++)
    begin : g_step
        always_comb
        begin
            logic signed [ACC_W-1:0] kk;
            kk          = ACC_W'($signed({1'b0, hs_reg[g-1].k}));
            hs_next[g]  = hs_reg[g-1];
            if (hs_reg[g-1].kind == KIND_SAMPLE)
            begin
                hs_next[g].acc_x = hs_reg[g-1].acc_x * kk + $signed(hs_reg[g-1].sx[g]);
                hs_next[g].acc_y = hs_reg[g-1].acc_y * kk + $signed(hs_reg[g-1].sy[g]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < NCOEF; i++)
            begin
                hv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (en)
            begin
                hv_reg[0] <= set_valid;
                for (int i = 1; i < NCOEF; i++)
                begin
                    hv_reg[i] <= hv_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                hs_reg[i] <= hs_next[i];
            end
        end
    end

    assign out_valid = hv_reg[DEGREE];
    assign out_slot  = hs_reg[DEGREE];

endmodule

`default_nettype wire

>>> rtl/core/qbz_round.sv
// Rounding divide by 100000 (reciprocal multiply plus one correction), ties away from
// zero, for samples only; four stages, the last is the output register. Uses qbz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbz_round (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire qbz_pkg::hslot_t          in_slot,
    output logic                          out_valid,
    output qbz_pkg::kind_t                out_kind,
    output logic [qbz_pkg::IDX_W-1:0]     out_idx,
    output logic                          out_last,
    output logic [qbz_pkg::VAL_W-1:0]     out_x,
    output logic [qbz_pkg::VAL_W-1:0]     out_y
);
    import qbz_pkg::*;

    localparam int M_W         = 32;
    localparam int Q_W         = 16;
    localparam int REM_W       = 18;
    localparam int RECIP_SHIFT = 40;
    localparam int PROD_W      = RECIP_SHIFT + Q_W;
    localparam int DIFF_W      = M_W + 2;
    localparam logic [M_W-1:0]    ROUND_HALF = 32'd50000;
    localparam logic [PROD_W-1:0] RECIP      = 56'd10995116;   // floor(2^40 / 100000)
    localparam logic [DIFF_W-1:0] SCALE_D    = 34'd100000;
    localparam logic [REM_W-1:0]  SCALE_R    = 18'd100000;

    typedef struct packed {
        logic              neg;
        logic [M_W-1:0]    m;      // |N| + half, or the raw coefficient
        logic [PROD_W-1:0] prod;
        logic [Q_W-1:0]    qe;
        logic [REM_W-1:0]  rem;
    } rax_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] idx;
        logic             last;
        rax_t             x;
        rax_t             y;
    } rslot_t;

    logic   v1_reg, v2_reg, v3_reg, vo_reg;
    rslot_t d1_reg, d2_reg, d3_reg, d1_next, d2_next, d3_next;
    kind_t  kind_reg;
    logic [IDX_W-1:0] idx_reg;
    logic   last_reg;
    logic [VAL_W-1:0] x_reg, y_reg, x_next, y_next;

    function automatic rax_t ax_abs(input logic signed [ACC_W-1:0] acc, input logic smp);
        rax_t r;
        logic signed [ACC_W-1:0] mag;
        r      = '0;
        r.neg  = smp && acc[ACC_W-1];
        mag    = r.neg ? -acc : acc;
        r.m    = smp ? (mag[M_W-1:0] + ROUND_HALF) : acc[M_W-1:0];
        return r;
    endfunction

    function automatic rax_t ax_rem(input rax_t a);
        rax_t r;
        logic [DIFF_W-1:0] diff;
        r    = a;
        r.qe = a.prod[RECIP_SHIFT +: Q_W];
        diff = DIFF_W'(a.m) - DIFF_W'(r.qe) * SCALE_D;
        r.rem = diff[REM_W-1:0];
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] ax_out(input rax_t a, input logic smp);
        logic [VAL_W-1:0] q;
        q = VAL_W'(a.qe) + ((a.rem >= SCALE_R) ? VAL_W'(1) : VAL_W'(0));
        if (!smp)
            return a.m[VAL_W-1:0];
        return a.neg ? -q : q;
    endfunction

    always_comb
    begin
        d1_next.kind = in_slot.kind;
        d1_next.idx  = in_slot.idx;
        d1_next.last = in_slot.last;
        d1_next.x    = ax_abs(in_slot.acc_x, in_slot.kind == KIND_SAMPLE);
        d1_next.y    = ax_abs(in_slot.acc_y, in_slot.kind == KIND_SAMPLE);

        d2_next        = d1_reg;
        d2_next.x.prod = PROD_W'(d1_reg.x.m) * RECIP;
        d2_next.y.prod = PROD_W'(d1_reg.y.m) * RECIP;

        d3_next   = d2_reg;
        d3_next.x = ax_rem(d2_reg.x);
        d3_next.y = ax_rem(d2_reg.y);

        x_next = ax_out(d3_reg.x, d3_reg.kind == KIND_SAMPLE);
        y_next = ax_out(d3_reg.y, d3_reg.kind == KIND_SAMPLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            d3_reg   <= d3_next;
            kind_reg <= d3_reg.kind;
            idx_reg  <= d3_reg.idx;
            last_reg <= d3_reg.last;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_kind  = kind_reg;
    assign out_idx   = idx_reg;
    assign out_last  = last_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

`default_nettype wire
